>>> rtl/core/ordered_array_insert_delete_search_top_assert.svh
// ----------------------------------------------------------------------------
// Ordered array assertion macros
// Shared assertion forms used by the checker of the ordered array block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OAIDS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OAIDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/oaids_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array package
// Types, codes and widths shared by the ordered array block.
// ----------------------------------------------------------------------------
package oaids_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CNT_W = 7;
  localparam int WORD_W = 32;
  localparam int CNT_MAX = 127;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  localparam logic signed [CNT_W-1:0] FOUND_NONE = -7'sd1;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_SEARCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

>>> rtl/core/oaids_if.sv
// ----------------------------------------------------------------------------
// Ordered array channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface oaids_req_if;
  logic                                   valid;
  logic                                   ready;
  oaids_pkg::req_t                        req_type;
  logic [oaids_pkg::CNT_W-1:0]            position;
  logic signed [oaids_pkg::WORD_W-1:0]    data_word;

  modport source(output valid, req_type, position, data_word, input ready);
  modport sink(input valid, req_type, position, data_word, output ready);
endinterface

interface oaids_rsp_if;
  logic                                   valid;
  logic                                   ready;
  oaids_pkg::status_t                     status;
  logic signed [oaids_pkg::CNT_W-1:0]     found_index;
  logic signed [oaids_pkg::WORD_W-1:0]    removed_word;
  logic [oaids_pkg::CNT_W-1:0]            list_length;

  modport source(output valid, status, found_index, removed_word, list_length,
                 input ready);
  modport sink(input valid, status, found_index, removed_word, list_length,
               output ready);
endinterface

>>> rtl/core/ordered_array_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// Ordered array with insert, delete and search
// A packed list of signed words kept in one memory and walked by a sequencer.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each produces exactly one item on
// the rsp channel. The user writes the capacity register through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce this.
// Append, insert at the end of the list, search on an empty list and every
// rejected request go from the accept straight to the response state, which
// presents the response item once the output register is free. Insert
// elsewhere moves one entry per cycle through the memory, reading each entry
// and writing it one place up. Delete moves the later entries one place down,
// and search walks from the head until a match or the end of the list. The
// block is ready for its next request in the same cycle as the response item is presented.
// The block takes one request at a time; req.ready is high only when idle.
// A finished response waits in the output register while a new request is
// accepted and worked on; the next response waits until it has been taken.
// Reset empties the list and sets the capacity to 64 entries. The memory
// contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search_top #(
  parameter int DEPTH = oaids_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  oaids_req_if.sink                    req,
  oaids_rsp_if.source                  rsp,
  input  logic                         cfg_wr_en,
  input  logic [oaids_pkg::CNT_W-1:0]  cfg_wr_data
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = oaids_pkg::CNT_W;
  localparam int WORD_W = oaids_pkg::WORD_W;
  localparam int CAP_MAX = (DEPTH < oaids_pkg::CNT_MAX) ? DEPTH : oaids_pkg::CNT_MAX;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_RESP
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     cap_reg;
  logic [CNT_W-1:0]     cap_eff;
  oaids_pkg::req_t      kind;
  logic [CNT_W-1:0]     pos;
  logic [WORD_W-1:0]    word;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     scan_end;
  logic                 issuing;
  logic                 rd_vld;
  logic                 rd_last;
  logic [CNT_W-1:0]     rd_idx;
  logic [WORD_W-1:0]    rd_data;
  oaids_pkg::status_t   res_status;
  logic [CNT_W-1:0]     res_found;
  logic [WORD_W-1:0]    res_removed;

  oaids_pkg::status_t   acc_status;
  logic                 acc_grow;
  logic                 acc_scan;
  logic [CNT_W-1:0]     acc_idx;

  logic [WORD_W-1:0]    mem [DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic                 req_fire;
  logic                 rsp_free;
  logic                 rsp_load;

  assign cap_eff = (cap_reg > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_reg;
  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;
  assign rsp_load = (state == S_RESP) && rsp_free;
  assign req.ready = (state == S_IDLE);
  assign scan_end = (kind == oaids_pkg::REQ_INSERT) ? pos : count - CNT_W'(1);

  always_comb begin
    acc_status = oaids_pkg::ST_OK;
    acc_grow = 1'b0;
    acc_scan = 1'b0;
    acc_idx = '0;
    unique case (req.req_type)
      oaids_pkg::REQ_APPEND: begin
        if (count >= cap_eff) begin
          acc_status = oaids_pkg::ST_FULL;
        end else begin
          acc_grow = 1'b1;
        end
      end
      oaids_pkg::REQ_INSERT: begin
        if (req.position > count) begin
          acc_status = oaids_pkg::ST_RANGE;
        end else if (count >= cap_eff) begin
          acc_status = oaids_pkg::ST_FULL;
        end else if (req.position == count) begin
          acc_grow = 1'b1;
        end else begin
          acc_scan = 1'b1;
          acc_idx = count - CNT_W'(1);
        end
      end
      oaids_pkg::REQ_DELETE: begin
        if (req.position >= count) begin
          acc_status = oaids_pkg::ST_RANGE;
        end else begin
          acc_scan = 1'b1;
          acc_idx = req.position;
        end
      end
      default: begin
        if (count == '0) begin
          acc_status = oaids_pkg::ST_NOTFOUND;
        end else begin
          acc_scan = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = ADDR_W'(count);
    mem_wdata = req.data_word;
    unique case (state)
      S_IDLE: begin
        if (req_fire && acc_grow) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN: begin
        mem_wdata = rd_data;
        if (rd_vld && kind == oaids_pkg::REQ_INSERT) begin
          mem_we = 1'b1;
          mem_waddr = ADDR_W'(rd_idx + CNT_W'(1));
        end else if (rd_vld && kind == oaids_pkg::REQ_DELETE && rd_idx != pos) begin
          mem_we = 1'b1;
          mem_waddr = ADDR_W'(rd_idx - CNT_W'(1));
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = ADDR_W'(pos);
        mem_wdata = word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[ADDR_W'(idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap_reg <= oaids_pkg::CAP_RESET;
      issuing <= 1'b0;
      rd_vld <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_reg <= cfg_wr_data;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          issuing <= req_fire && acc_scan;
          if (req_fire) begin
            kind <= req.req_type;
            pos <= req.position;
            word <= req.data_word;
            res_status <= acc_status;
            res_found <= oaids_pkg::FOUND_NONE;
            res_removed <= '0;
            idx <= acc_idx;
            if (acc_grow) begin
              count <= count + CNT_W'(1);
            end
            state <= acc_scan ? S_SCAN : S_RESP;
          end
        end
        S_SCAN: begin
          rd_vld <= issuing;
          rd_idx <= idx;
          rd_last <= issuing && idx == scan_end;
          if (issuing) begin
            if (idx == scan_end) begin
              issuing <= 1'b0;
            end else if (kind == oaids_pkg::REQ_INSERT) begin
              idx <= idx - CNT_W'(1);
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end
          if (rd_vld) begin
            if (kind == oaids_pkg::REQ_DELETE && rd_idx == pos) begin
              res_removed <= rd_data;
            end
            if (kind == oaids_pkg::REQ_SEARCH && rd_data == word) begin
              res_found <= rd_idx;
              state <= S_RESP;
            end else if (rd_last) begin
              unique case (kind)
                oaids_pkg::REQ_INSERT: begin
                  state <= S_PUT;
                end
                oaids_pkg::REQ_DELETE: begin
                  count <= count - CNT_W'(1);
                  state <= S_RESP;
                end
                default: begin
                  res_status <= oaids_pkg::ST_NOTFOUND;
                  state <= S_RESP;
                end
              endcase
            end
          end
        end
        S_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp.status <= res_status;
            rsp.found_index <= res_found;
            rsp.removed_word <= res_removed;
            rsp.list_length <= count;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/oaids_checker.sv
// ----------------------------------------------------------------------------
// Ordered array checker
// Port level checks of the ordered array block, bound to its top level.
// ----------------------------------------------------------------------------
`include "ordered_array_insert_delete_search_top_assert.svh"

module oaids_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input oaids_pkg::status_t                   rsp_status,
  input logic signed [oaids_pkg::CNT_W-1:0]   rsp_found_index,
  input logic signed [oaids_pkg::WORD_W-1:0]  rsp_removed_word
);

  // The block works on one item at a time, so it is busy right after accept.
  `OAIDS_ASSERT_NEXT(busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "ready after accept")

  `OAIDS_ASSERT_NEXT(rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

  `OAIDS_ASSERT_SAME(notfound_fields, clk, rst, rsp_valid && rsp_status == oaids_pkg::ST_NOTFOUND, rsp_found_index == oaids_pkg::FOUND_NONE && rsp_removed_word == '0, "bad not found item")

  `OAIDS_ASSERT_SAME(found_only_ok, clk, rst, rsp_valid && rsp_found_index != oaids_pkg::FOUND_NONE, rsp_status == oaids_pkg::ST_OK && rsp_removed_word == '0, "bad found item")

endmodule

bind ordered_array_insert_delete_search_top oaids_checker u_oaids_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found_index  (rsp.found_index),
  .rsp_removed_word (rsp.removed_word)
);

>>> test/tb_ordered_array_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// Ordered array testbench
// A table of directed requests runs first. Random phases follow, each under a
// new capacity setting. Every response item is compared with the item that its
// table row gives or else with the output of a shadow list that the bench keeps.
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete_search_top;

  localparam int LIST_DEPTH = oaids_pkg::DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 83;
  localparam int NUM_PHASES = 9;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    oaids_pkg::status_t status;
    logic signed [6:0]  found_index;
    logic signed [31:0] removed_word;
    logic [6:0]         list_length;
  } list_rsp_t;

  typedef struct packed {
    oaids_pkg::req_t    req_type;
    logic [6:0]         position;
    logic signed [31:0] data_word;
    logic               typed;
    list_rsp_t          want;
  } list_req_t;

  localparam list_rsp_t UNTYPED = '{oaids_pkg::ST_OK, 7'sd0, 32'sd0, 7'd0};

  // The list holds 5 entries when the table ends.
  list_req_t request_table [NUM_ROWS] = '{
    '{oaids_pkg::REQ_SEARCH, 7'd0,   32'sd0,        1'b1,
      '{oaids_pkg::ST_NOTFOUND, oaids_pkg::FOUND_NONE, 32'sd0, 7'd0}},
    '{oaids_pkg::REQ_DELETE, 7'd0,   32'sd0,        1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd0}},
    '{oaids_pkg::REQ_INSERT, 7'd1,   32'sd1,        1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd0}},
    '{oaids_pkg::REQ_INSERT, 7'd0,   32'sh7FFFFFFF, 1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd1}},
    '{oaids_pkg::REQ_APPEND, 7'd0,   32'sh80000000, 1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd2}},
    '{oaids_pkg::REQ_APPEND, 7'd0,   -32'sd1,       1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd3}},
    '{oaids_pkg::REQ_APPEND, 7'd0,   32'sd0,        1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd4}},
    '{oaids_pkg::REQ_INSERT, 7'd4,   32'sd5,        1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd5}},
    '{oaids_pkg::REQ_INSERT, 7'd2,   32'sh55555555, 1'b0, UNTYPED},
    '{oaids_pkg::REQ_INSERT, 7'd7,   32'shAAAAAAAA, 1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd6}},
    '{oaids_pkg::REQ_INSERT, 7'd127, 32'sh12345678, 1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd6}},
    '{oaids_pkg::REQ_SEARCH, 7'd127, 32'sh80000000, 1'b0, UNTYPED},
    '{oaids_pkg::REQ_SEARCH, 7'd0,   32'sh2AAAAAAA, 1'b1,
      '{oaids_pkg::ST_NOTFOUND, oaids_pkg::FOUND_NONE, 32'sd0, 7'd6}},
    '{oaids_pkg::REQ_APPEND, 7'd127, -32'sd1,       1'b0, UNTYPED},
    '{oaids_pkg::REQ_SEARCH, 7'd0,   -32'sd1,       1'b0, UNTYPED},
    '{oaids_pkg::REQ_DELETE, 7'd7,   32'sd0,        1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd7}},
    '{oaids_pkg::REQ_DELETE, 7'd127, 32'sd0,        1'b1,
      '{oaids_pkg::ST_RANGE, oaids_pkg::FOUND_NONE, 32'sd0, 7'd7}},
    '{oaids_pkg::REQ_DELETE, 7'd0,   32'sd0,        1'b1,
      '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sh7FFFFFFF, 7'd6}},
    '{oaids_pkg::REQ_DELETE, 7'd5,   32'sd0,        1'b0, UNTYPED},
    '{oaids_pkg::REQ_DELETE, 7'd1,   32'sd0,        1'b0, UNTYPED},
    '{oaids_pkg::REQ_INSERT, 7'd0,   32'sd0,        1'b0, UNTYPED},
    '{oaids_pkg::REQ_SEARCH, 7'd0,   32'sd0,        1'b0, UNTYPED},
    '{oaids_pkg::REQ_SEARCH, 7'd0,   32'sd5,        1'b0, UNTYPED}
  };

  // The first phase lowers the capacity below the count left by the table.
  int phase_caps [NUM_PHASES] = '{3, 0, 1, 64, 127, 2, 40, 64, 127};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [oaids_pkg::CNT_W-1:0] cfg_wr_data = '0;
  logic rsp_take = 1'b0;
  bit steady_run = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  logic signed [31:0] shadow_list [LIST_DEPTH];
  int shadow_len = 0;
  int shadow_cap = 64;
  list_rsp_t pending_rsp [$];

  oaids_req_if req_ch();
  oaids_rsp_if rsp_ch();

  assign rsp_ch.ready = rsp_take;

  ordered_array_insert_delete_search_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_take <= steady_run || ($urandom_range(0, 99) >= 11);
  end

  // Applies one request to the shadow list and returns the response it gives.
  task automatic apply_list_request(input list_req_t rq, output list_rsp_t rs);
    int lim;
    int idx;
    rs = '{oaids_pkg::ST_OK, oaids_pkg::FOUND_NONE, 32'sd0, 7'd0};
    lim = (shadow_cap < LIST_DEPTH) ? shadow_cap : LIST_DEPTH;
    case (rq.req_type)
      oaids_pkg::REQ_APPEND: begin
        if (shadow_len >= lim) begin
          rs.status = oaids_pkg::ST_FULL;
        end else begin
          shadow_list[shadow_len] = rq.data_word;
          shadow_len++;
        end
      end
      oaids_pkg::REQ_INSERT: begin
        if (int'(rq.position) > shadow_len) begin
          rs.status = oaids_pkg::ST_RANGE;
        end else if (shadow_len >= lim) begin
          rs.status = oaids_pkg::ST_FULL;
        end else begin
          for (idx = shadow_len; idx > int'(rq.position); idx--) begin
            shadow_list[idx] = shadow_list[idx-1];
          end
          shadow_list[rq.position] = rq.data_word;
          shadow_len++;
        end
      end
      oaids_pkg::REQ_DELETE: begin
        if (int'(rq.position) >= shadow_len) begin
          rs.status = oaids_pkg::ST_RANGE;
        end else begin
          rs.removed_word = shadow_list[rq.position];
          for (idx = int'(rq.position); idx + 1 < shadow_len; idx++) begin
            shadow_list[idx] = shadow_list[idx+1];
          end
          shadow_len--;
        end
      end
      default: begin
        rs.status = oaids_pkg::ST_NOTFOUND;
        // Scanning downward leaves the lowest matching index.
        for (idx = shadow_len - 1; idx >= 0; idx--) begin
          if (shadow_list[idx] == rq.data_word) begin
            rs.status = oaids_pkg::ST_OK;
            rs.found_index = 7'(idx);
          end
        end
      end
    endcase
    rs.list_length = 7'(shadow_len);
  endtask

  task automatic send_request(input list_req_t rq);
    list_rsp_t rs;
    @(negedge clk);
    while (!steady_run && $urandom_range(0, 99) < 11) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq.req_type;
    req_ch.position <= rq.position;
    req_ch.data_word <= rq.data_word;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_list_request(rq, rs);
    pending_rsp.push_back(rq.typed ? rq.want : rs);
  endtask

  task automatic settle_block();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_take) begin
      if (pending_rsp.size() == 0) begin
        $error("response item arrived with no request waiting");
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index,
                 rsp_ch.found_index);
          mismatches++;
        end
        if (rsp_ch.removed_word !== want.removed_word) begin
          $error("removed_word: expected %0d, got %0d", want.removed_word,
                 rsp_ch.removed_word);
          mismatches++;
        end
        if (rsp_ch.list_length !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length,
                 rsp_ch.list_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    list_req_t rq;
    int r;
    bit growing;
    req_ch.valid = 1'b0;
    req_ch.req_type = oaids_pkg::REQ_APPEND;
    req_ch.position = '0;
    req_ch.data_word = '0;
    growing = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (request_table[row]) begin
      send_request(request_table[row]);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= 7'(phase_caps[ph]);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      shadow_cap = phase_caps[ph];
      steady_run = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Fill the list toward its limit, then drain it, with random turns.
        if (shadow_len == 0) begin
          growing = 1'b1;
        end else if (shadow_len >= ((shadow_cap < LIST_DEPTH) ? shadow_cap : LIST_DEPTH)) begin
          growing = 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
          growing = !growing;
        end
        r = $urandom_range(0, 99);
        if (growing) begin
          rq.req_type = (r < 35) ? oaids_pkg::REQ_APPEND :
                        (r < 65) ? oaids_pkg::REQ_INSERT :
                        (r < 80) ? oaids_pkg::REQ_DELETE : oaids_pkg::REQ_SEARCH;
        end else begin
          rq.req_type = (r < 10) ? oaids_pkg::REQ_APPEND :
                        (r < 20) ? oaids_pkg::REQ_INSERT :
                        (r < 70) ? oaids_pkg::REQ_DELETE : oaids_pkg::REQ_SEARCH;
        end
        r = $urandom_range(0, 99);
        if (rq.req_type == oaids_pkg::REQ_INSERT && r < 90) begin
          rq.position = 7'($urandom_range(0, shadow_len));
        end else if (rq.req_type == oaids_pkg::REQ_DELETE && shadow_len > 0 && r < 90) begin
          rq.position = 7'($urandom_range(0, shadow_len - 1));
        end else begin
          rq.position = 7'($urandom_range(0, 127));
        end
        r = $urandom_range(0, 99);
        if (r < 25 && shadow_len > 0) begin
          rq.data_word = shadow_list[$urandom_range(0, shadow_len - 1)];
        end else if (r < 45) begin
          rq.data_word = $signed(32'($urandom_range(0, 7))) - 32'sd3;
        end else begin
          rq.data_word = $urandom;
        end
        rq.typed = 1'b0;
        rq.want = UNTYPED;
        send_request(rq);
      end
      steady_run = 1'b0;
    end

    settle_block();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/oaids_pkg.sv
rtl/core/oaids_if.sv
rtl/core/ordered_array_insert_delete_search_top.sv
rtl/core/oaids_checker.sv
test/tb_ordered_array_insert_delete_search_top.sv
